// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, off while reset is low.
`define CDP_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Hold a signal steady in the cycle after a condition.
`define CDP_ASSERT_HOLD(label, clk, rst_n, cond, sig, msg) \
	`CDP_ASSERT(label, clk, rst_n, (cond) |=> $stable(sig), msg)

`endif

// ===== hdl/cdp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cdp_pkg;

	localparam int WORD_BITS_DEF  = 32;
	localparam int SUB_BLOCKS_DEF = 4;
	localparam int TAIL_BITS_DEF  = 24;
	localparam int SOFT_WIDTH_DEF = 16;

	localparam int MAX_RESULTS = 8;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	localparam int PAT_W      = 64;
	localparam int WORD_REG_W = 32;
	localparam int TAIL_REG_W = 24;
	localparam int LEN_W      = 12;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_ADDR_W = 3;
	localparam int SEG_W      = 3;

	localparam logic [SEG_W-1:0] SEG_TAIL = SEG_W'(4);

	typedef enum logic [CFG_ADDR_W-1:0] {
		CFG_PAT_FIRST  = 3'd0,
		CFG_PAT_SECOND = 3'd1,
		CFG_LEN_ONE    = 3'd2,
		CFG_LEN_TWO    = 3'd3,
		CFG_LEN_THREE  = 3'd4,
		CFG_LEN_FOUR   = 3'd5,
		CFG_TAIL       = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic load;
		logic emit;
		logic shadow_adv;
	} cdp_cmd_t;

	typedef struct packed {
		logic cur_bit;
		logic cur_end;
		logic sh_bit;
		logic sh_end;
		logic out_free;
	} cdp_sts_t;

endpackage

`default_nettype wire

// ===== hdl/convolutional_depuncturer_top.sv =====
// Flow: an accepted input word is registered, then the walk state emits its first output
// word once the output is free. The walk covers k positions (1..8), one a cycle while the
// output is free; a shadow scan follows a kept position, and t trailing punctured positions
// to the frame end (0..7) follow likewise. Input is taken again only when all are done.
// Reset: asynchronous, clears the walk to the first position of segment one, loads default
// config (all-kept words, segment one of length 1) and drops any pending output.
`timescale 1ns / 1ps
`default_nettype none

module convolutional_depuncturer_top #(
	parameter int WORD_BITS  = cdp_pkg::WORD_BITS_DEF,
	parameter int SUB_BLOCKS = cdp_pkg::SUB_BLOCKS_DEF,
	parameter int TAIL_BITS  = cdp_pkg::TAIL_BITS_DEF,
	parameter int SOFT_WIDTH = cdp_pkg::SOFT_WIDTH_DEF
) (
	input  wire                                      clk,
	input  wire                                      arst_n,
	input  wire                                      cfg_we,
	input  wire  [cdp_pkg::CFG_ADDR_W-1:0]           cfg_addr,
	input  wire  [cdp_pkg::CFG_DATA_W-1:0]           cfg_wdata,
	input  wire                                      s_tvalid,
	output logic                                     s_tready,
	input  wire  [((SOFT_WIDTH + 7) / 8) * 8 - 1:0]  s_tdata,  // soft_in
	output logic                                     m_tvalid,
	input  wire                                      m_tready,
	output logic [((SOFT_WIDTH + 7) / 8) * 8 - 1:0]  m_tdata,  // soft_out
	output logic                                     m_tlast   // frame_end
);

	localparam int TDATA_W = ((SOFT_WIDTH + 7) / 8) * 8;

	cdp_pkg::cdp_cmd_t cmd;
	cdp_pkg::cdp_sts_t sts;

	cdp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cdp_datapath #(
		.WORD_BITS  (WORD_BITS),
		.SUB_BLOCKS (SUB_BLOCKS),
		.TAIL_BITS  (TAIL_BITS),
		.SOFT_WIDTH (SOFT_WIDTH),
		.TDATA_W    (TDATA_W)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

`default_nettype wire

// ===== hdl/cdp_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cdp_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               s_tvalid,
	output logic              s_tready,
	input  cdp_pkg::cdp_sts_t sts,
	output cdp_pkg::cdp_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_SCAN,
		ST_TAIL
	} state_t;

	state_t                      state_q;
	logic [cdp_pkg::CNT_W-1:0]   cnt_q;
	logic [cdp_pkg::CNT_W-1:0]   n_q;
	logic                        budget_out;

	assign s_tready = (state_q == ST_IDLE);

	assign budget_out = ((cdp_pkg::CNT_W + 1)'(cnt_q) + (cdp_pkg::CNT_W + 1)'(n_q))
		>= (cdp_pkg::CNT_W + 1)'(cdp_pkg::MAX_RESULTS);

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: cmd.load = s_tvalid;
			ST_WALK: cmd.emit = sts.out_free;
			ST_SCAN: cmd.shadow_adv = !budget_out && !sts.sh_bit && !sts.sh_end;
			ST_TAIL: cmd.emit = sts.out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			n_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						cnt_q   <= '0;
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (sts.out_free) begin
						cnt_q <= cnt_q + 1'b1;
						if (sts.cur_bit) begin
							n_q     <= '0;
							state_q <= sts.cur_end ? ST_IDLE : ST_SCAN;
						end else if (cnt_q == cdp_pkg::CNT_W'(cdp_pkg::MAX_RESULTS - 1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_SCAN: begin
					if (budget_out || sts.sh_bit) begin
						state_q <= ST_IDLE;
					end else begin
						n_q <= n_q + 1'b1;
						if (sts.sh_end) begin
							state_q <= ST_TAIL;
						end
					end
				end
				ST_TAIL: begin
					if (sts.out_free) begin
						n_q <= n_q - 1'b1;
						if (n_q == cdp_pkg::CNT_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hdl/cdp_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cdp_datapath #(
	parameter int WORD_BITS  = cdp_pkg::WORD_BITS_DEF,
	parameter int SUB_BLOCKS = cdp_pkg::SUB_BLOCKS_DEF,
	parameter int TAIL_BITS  = cdp_pkg::TAIL_BITS_DEF,
	parameter int SOFT_WIDTH = cdp_pkg::SOFT_WIDTH_DEF,
	parameter int TDATA_W    = ((SOFT_WIDTH + 7) / 8) * 8
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_we,
	input  wire  [cdp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  wire  [cdp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  wire  [TDATA_W-1:0]               s_tdata,
	output logic                             m_tvalid,
	input  wire                              m_tready,
	output logic [TDATA_W-1:0]               m_tdata,
	output logic                             m_tlast,
	input  cdp_pkg::cdp_cmd_t                cmd,
	output cdp_pkg::cdp_sts_t                sts
);

	localparam int BP_W = $clog2((WORD_BITS > TAIL_BITS) ? WORD_BITS : TAIL_BITS);
	localparam int WR_W = cdp_pkg::LEN_W + $clog2(SUB_BLOCKS);
	localparam logic [BP_W:0] WORD_LAST = (BP_W + 1)'(WORD_BITS - 1);
	localparam logic [BP_W:0] TAIL_LAST = (BP_W + 1)'(TAIL_BITS - 1);

	typedef struct packed {
		logic [cdp_pkg::SEG_W-1:0] seg;
		logic [WR_W-1:0]           wr;
		logic [BP_W-1:0]           bp;
	} walk_t;

	logic [cdp_pkg::PAT_W-1:0]      pat_first_q;
	logic [cdp_pkg::PAT_W-1:0]      pat_second_q;
	logic [cdp_pkg::LEN_W-1:0]      len_q [4];
	logic [cdp_pkg::TAIL_REG_W-1:0] tail_q;

	walk_t                  walk_q;
	walk_t                  sh_q;
	walk_t                  walk_nxt;
	walk_t                  sh_nxt;
	logic [SOFT_WIDTH-1:0]  soft_q;
	logic                   out_valid_q;
	logic [SOFT_WIDTH-1:0]  out_soft_q;
	logic                   out_last_q;

	function automatic walk_t settle(input walk_t w);
		walk_t           r;
		logic [WR_W-1:0] words;
		r = w;
		if (r.seg > cdp_pkg::SEG_TAIL) begin
			r = '0;
		end
		for (int k = 0; k < 4; k++) begin
			words = WR_W'(len_q[k]) * WR_W'(SUB_BLOCKS);
			if (r.seg == cdp_pkg::SEG_W'(k) && r.wr >= words) begin
				r.seg = cdp_pkg::SEG_W'(k + 1);
				r.wr  = '0;
				r.bp  = '0;
			end
		end
		return r;
	endfunction

	function automatic logic is_end(input walk_t w);
		return (w.seg >= cdp_pkg::SEG_TAIL) && ({1'b0, w.bp} >= TAIL_LAST);
	endfunction

	function automatic walk_t step(input walk_t w);
		walk_t r;
		r = w;
		if (w.seg >= cdp_pkg::SEG_TAIL) begin
			if ({1'b0, w.bp} >= TAIL_LAST) begin
				r = '0;
			end else begin
				r.bp = w.bp + 1'b1;
			end
		end else if ({1'b0, w.bp} >= WORD_LAST) begin
			r.bp = '0;
			r.wr = w.wr + 1'b1;
		end else begin
			r.bp = w.bp + 1'b1;
		end
		return settle(r);
	endfunction

	function automatic logic kept(input walk_t w);
		logic [cdp_pkg::WORD_REG_W-1:0] word;
		logic [4:0]                     idx;
		idx = 5'(w.bp);
		case (w.seg)
			3'd0:    word = pat_first_q[cdp_pkg::WORD_REG_W-1:0];
			3'd1:    word = pat_first_q[cdp_pkg::PAT_W-1:cdp_pkg::WORD_REG_W];
			3'd2:    word = pat_second_q[cdp_pkg::WORD_REG_W-1:0];
			3'd3:    word = pat_second_q[cdp_pkg::PAT_W-1:cdp_pkg::WORD_REG_W];
			default: word = cdp_pkg::WORD_REG_W'(tail_q);
		endcase
		return word[idx];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_first_q  <= '1;
			pat_second_q <= '1;
			len_q[0]     <= cdp_pkg::LEN_W'(1);
			len_q[1]     <= '0;
			len_q[2]     <= '0;
			len_q[3]     <= '0;
			tail_q       <= '1;
		end else if (cfg_we) begin
			case (cdp_pkg::cfg_reg_t'(cfg_addr))
				cdp_pkg::CFG_PAT_FIRST:  pat_first_q  <= cfg_wdata;
				cdp_pkg::CFG_PAT_SECOND: pat_second_q <= cfg_wdata;
				cdp_pkg::CFG_LEN_ONE:    len_q[0] <= cfg_wdata[cdp_pkg::LEN_W-1:0];
				cdp_pkg::CFG_LEN_TWO:    len_q[1] <= cfg_wdata[cdp_pkg::LEN_W-1:0];
				cdp_pkg::CFG_LEN_THREE:  len_q[2] <= cfg_wdata[cdp_pkg::LEN_W-1:0];
				cdp_pkg::CFG_LEN_FOUR:   len_q[3] <= cfg_wdata[cdp_pkg::LEN_W-1:0];
				cdp_pkg::CFG_TAIL:       tail_q   <= cfg_wdata[cdp_pkg::TAIL_REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		walk_nxt     = step(walk_q);
		sh_nxt       = step(sh_q);
		sts.cur_bit  = kept(walk_q);
		sts.cur_end  = is_end(walk_q);
		sts.sh_bit   = kept(sh_q);
		sts.sh_end   = is_end(sh_q);
		sts.out_free = !out_valid_q || m_tready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q <= '0;
			sh_q   <= '0;
		end else if (cmd.load) begin
			walk_q <= settle(walk_q);
		end else if (cmd.emit) begin
			walk_q <= walk_nxt;
			sh_q   <= walk_nxt;
		end else if (cmd.shadow_adv) begin
			sh_q <= sh_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			soft_q <= s_tdata[SOFT_WIDTH-1:0];
		end
		if (cmd.emit) begin
			out_soft_q <= kept(walk_q) ? soft_q : '0;
			out_last_q <= is_end(walk_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = TDATA_W'(out_soft_q);
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire

// ===== hdl/cdp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cdp_checker #(
	parameter int SOFT_WIDTH = cdp_pkg::SOFT_WIDTH_DEF
) (
	input wire                                      clk,
	input wire                                      arst_n,
	input wire                                      s_tvalid,
	input wire                                      s_tready,
	input wire                                      m_tvalid,
	input wire                                      m_tready,
	input wire [((SOFT_WIDTH + 7) / 8) * 8 - 1:0]   m_tdata,
	input wire                                      m_tlast
);

	logic [((SOFT_WIDTH + 7) / 8) * 8:0] out_word;

	assign out_word = {m_tdata, m_tlast};

	`CDP_ASSERT(a_out_valid_held, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid, "word dropped")
	`CDP_ASSERT_HOLD(a_out_data_held, clk, arst_n, m_tvalid && !m_tready, out_word, "word changed")
	`CDP_ASSERT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready |=> !s_tready, "overrun")
	`CDP_ASSERT(a_out_from_busy, clk, arst_n, $rose(m_tvalid) |-> !$past(s_tready), "no input")

endmodule

bind convolutional_depuncturer_top cdp_checker #(.SOFT_WIDTH(SOFT_WIDTH)) u_cdp_checker (.*);

`default_nettype wire

// ===== sim/tb_convolutional_depuncturer_top.sv =====
`timescale 1ns / 1ps

module tb_convolutional_depuncturer_top;

	localparam int WORD_LEN = cdp_pkg::WORD_BITS_DEF;
	localparam int BLOCKS   = cdp_pkg::SUB_BLOCKS_DEF;
	localparam int TAIL_LEN = cdp_pkg::TAIL_BITS_DEF;
	localparam int SETTLE_CYCLES = 32;
	localparam int RANDOM_PER_SETTING = 29;

	typedef struct packed {
		logic        last;
		logic [15:0] val;
	} exp_t;

	typedef struct packed {
		logic              is_cfg;
		cdp_pkg::cfg_reg_t addr;
		logic [63:0]       value;
		logic [15:0]       din;
		logic              typed;
		logic [15:0]       want_soft;
		logic              want_last;
	} row_t;

	localparam int PLAN_LEN = 30;
	row_t plan [0:PLAN_LEN-1] = '{
		'{1'b0, cdp_pkg::CFG_PAT_FIRST, 64'd0, 16'h7FFF, 1'b1, 16'h7FFF, 1'b0},
		'{1'b0, cdp_pkg::CFG_PAT_FIRST, 64'd0, 16'h8000, 1'b1, 16'h8000, 1'b0},
		'{1'b0, cdp_pkg::CFG_PAT_FIRST, 64'd0, 16'h0000, 1'b1, 16'h0000, 1'b0},
		'{1'b0, cdp_pkg::CFG_PAT_FIRST, 64'd0, 16'hFFFF, 1'b1, 16'hFFFF, 1'b0},
		'{1'b0, cdp_pkg::CFG_PAT_FIRST, 64'd0, 16'h1234, 1'b0, 16'h0000, 1'b0},
		'{1'b1, cdp_pkg::CFG_LEN_ONE, 64'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
		'{1'b1, cdp_pkg::CFG_TAIL, 64'h249249, 16'h0000, 1'b0, 16'h0000, 1'b0},
		'{1'b0, cdp_pkg::CFG_PAT_FIRST, 64'd0, 16'hA5A5, 1'b0, 16'h0000, 1'b0},
		'{1'b0, cdp_pkg::CFG_PAT_FIRST, 64'd0, 16'h5A5A, 1'b0, 16'h0000, 1'b0},
		'{1'b0, cdp_pkg::CFG_PAT_FIRST, 64'd0, 16'h0001, 1'b0, 16'h0000, 1'b0},
		'{1'b0, cdp_pkg::CFG_PAT_FIRST, 64'd0, 16'hFFFE, 1'b0, 16'h0000, 1'b0},
		'{1'b0, cdp_pkg::CFG_PAT_FIRST, 64'd0, 16'h4000, 1'b0, 16'h0000, 1'b0},
		'{1'b0, cdp_pkg::CFG_PAT_FIRST, 64'd0, 16'hC000, 1'b0, 16'h0000, 1'b0},
		'{1'b0, cdp_pkg::CFG_PAT_FIRST, 64'd0, 16'h7FFE, 1'b0, 16'h0000, 1'b0},
		'{1'b0, cdp_pkg::CFG_PAT_FIRST, 64'd0, 16'h8001, 1'b0, 16'h0000, 1'b0},
		'{1'b1, cdp_pkg::CFG_TAIL, 64'h0, 16'h0000, 1'b0, 16'h0000, 1'b0},
		'{1'b1, cdp_pkg::CFG_PAT_FIRST, 64'h8000_0000_7777_7777, 16'h0000, 1'b0,
			16'h0000, 1'b0},
		'{1'b1, cdp_pkg::CFG_LEN_TWO, 64'd1, 16'h0000, 1'b0, 16'h0000, 1'b0},
		'{1'b0, cdp_pkg::CFG_PAT_FIRST, 64'd0, 16'h1111, 1'b0, 16'h0000, 1'b0},
		'{1'b0, cdp_pkg::CFG_PAT_FIRST, 64'd0, 16'h2222, 1'b0, 16'h0000, 1'b0},
		'{1'b0, cdp_pkg::CFG_PAT_FIRST, 64'd0, 16'h3333, 1'b0, 16'h0000, 1'b0},
		'{1'b0, cdp_pkg::CFG_PAT_FIRST, 64'd0, 16'h4444, 1'b0, 16'h0000, 1'b0},
		'{1'b0, cdp_pkg::CFG_PAT_FIRST, 64'd0, 16'h5555, 1'b0, 16'h0000, 1'b0},
		'{1'b0, cdp_pkg::CFG_PAT_FIRST, 64'd0, 16'h6666, 1'b0, 16'h0000, 1'b0},
		'{1'b0, cdp_pkg::CFG_PAT_FIRST, 64'd0, 16'h7777, 1'b0, 16'h0000, 1'b0},
		'{1'b0, cdp_pkg::CFG_PAT_FIRST, 64'd0, 16'h8888, 1'b0, 16'h0000, 1'b0},
		'{1'b1, cdp_pkg::CFG_LEN_TWO, 64'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
		'{1'b1, cdp_pkg::CFG_TAIL, 64'hFFFFFF, 16'h0000, 1'b0, 16'h0000, 1'b0},
		'{1'b0, cdp_pkg::CFG_PAT_FIRST, 64'd0, 16'h9999, 1'b0, 16'h0000, 1'b0},
		'{1'b0, cdp_pkg::CFG_PAT_FIRST, 64'd0, 16'hAAAA, 1'b0, 16'h0000, 1'b0}
	};

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [cdp_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [cdp_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [15:0]                    s_tdata = '0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [15:0]                    m_tdata;
	logic                           m_tlast;

	logic [63:0] pat_first;
	logic [63:0] pat_second;
	logic [11:0] seg_len [4];
	logic [23:0] tail_word;
	logic [2:0]  seg_at;
	logic [13:0] rep_at;
	logic [4:0]  pos_at;

	exp_t step_words [$];
	exp_t due_words [$];
	int   mismatches = 0;
	int   tx_pct = 0;
	int   rx_pct = 0;

	convolutional_depuncturer_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void normalize();
		if (seg_at > cdp_pkg::SEG_TAIL) begin
			seg_at = '0;
			rep_at = '0;
			pos_at = '0;
		end
		while (seg_at < cdp_pkg::SEG_TAIL
			&& int'(rep_at) >= int'(seg_len[seg_at[1:0]]) * BLOCKS) begin
			seg_at = seg_at + 3'd1;
			rep_at = '0;
			pos_at = '0;
		end
	endfunction

	function automatic logic kept_here();
		logic [31:0] w;
		case (seg_at)
			3'd0: w = pat_first[31:0];
			3'd1: w = pat_first[63:32];
			3'd2: w = pat_second[31:0];
			3'd3: w = pat_second[63:32];
			default: w = {8'h00, tail_word};
		endcase
		return w[pos_at];
	endfunction

	function automatic logic at_frame_end();
		return seg_at >= cdp_pkg::SEG_TAIL && int'(pos_at) + 1 >= TAIL_LEN;
	endfunction

	function automatic void step_pos();
		if (seg_at >= cdp_pkg::SEG_TAIL) begin
			if (int'(pos_at) + 1 >= TAIL_LEN) begin
				seg_at = '0;
				rep_at = '0;
				pos_at = '0;
			end else begin
				pos_at = pos_at + 5'd1;
			end
		end else if (int'(pos_at) + 1 >= WORD_LEN) begin
			pos_at = '0;
			rep_at = rep_at + 14'd1;
		end else begin
			pos_at = pos_at + 5'd1;
		end
		normalize();
	endfunction

	function automatic void apply_reg(input cdp_pkg::cfg_reg_t a, input logic [63:0] v);
		case (a)
			cdp_pkg::CFG_PAT_FIRST:  pat_first = v;
			cdp_pkg::CFG_PAT_SECOND: pat_second = v;
			cdp_pkg::CFG_LEN_ONE:    seg_len[0] = v[11:0];
			cdp_pkg::CFG_LEN_TWO:    seg_len[1] = v[11:0];
			cdp_pkg::CFG_LEN_THREE:  seg_len[2] = v[11:0];
			cdp_pkg::CFG_LEN_FOUR:   seg_len[3] = v[11:0];
			cdp_pkg::CFG_TAIL:       tail_word = v[23:0];
			default: ;
		endcase
	endfunction

	function automatic void depuncture(input logic [15:0] din);
		int   n;
		int   lead;
		int   i;
		logic took;
		logic closed;
		logic hits;
		logic kb;
		exp_t e;
		logic [2:0]  s_seg;
		logic [13:0] s_rep;
		logic [4:0]  s_pos;
		step_words.delete();
		n = 0;
		lead = 0;
		took = 1'b0;
		closed = 1'b0;
		hits = 1'b0;
		normalize();
		while (n < cdp_pkg::MAX_RESULTS && !took) begin
			kb = kept_here();
			e.last = at_frame_end();
			e.val = kb ? din : 16'h0000;
			step_words.push_back(e);
			n++;
			step_pos();
			took = kb;
			closed = e.last;
		end
		if (took && !closed) begin
			s_seg = seg_at;
			s_rep = rep_at;
			s_pos = pos_at;
			while (n + lead < cdp_pkg::MAX_RESULTS) begin
				if (kept_here())
					break;
				lead++;
				if (at_frame_end()) begin
					hits = 1'b1;
					break;
				end
				step_pos();
			end
			seg_at = s_seg;
			rep_at = s_rep;
			pos_at = s_pos;
			if (hits) begin
				for (i = 0; i < lead; i++) begin
					e.last = at_frame_end();
					e.val = 16'h0000;
					step_words.push_back(e);
					step_pos();
				end
			end
		end
	endfunction

	function automatic logic [31:0] shaped_word();
		logic [31:0] w;
		int          run;
		int          i;
		if ($urandom_range(0, 4) == 0)
			return $urandom;
		run = 0;
		for (i = 0; i < 32; i++) begin
			if (run < 3 && $urandom_range(0, 99) < 35) begin
				w[i] = 1'b0;
				run++;
			end else begin
				w[i] = 1'b1;
				run = 0;
			end
		end
		return w;
	endfunction

	function automatic logic [11:0] pick_len();
		case ($urandom_range(0, 9))
			0: return 12'd4095;
			1: return 12'($urandom_range(0, 4095));
			2, 3, 4, 5: return 12'd0;
			default: return 12'($urandom_range(1, 2));
		endcase
	endfunction

	function automatic logic [15:0] pick_soft();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic drain();
		while (due_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_reg(input cdp_pkg::cfg_reg_t a, input logic [63:0] v);
		cfg_we <= 1'b1;
		cfg_addr <= a;
		cfg_wdata <= v;
		apply_reg(a, v);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_word(input logic [15:0] v, input logic typed, input exp_t want);
		while ($urandom_range(0, 99) < tx_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= v;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		depuncture(v);
		if (typed)
			due_words.push_back(want);
		else
			foreach (step_words[i])
				due_words.push_back(step_words[i]);
	endtask

	task automatic load_setting(input int k);
		logic [11:0] l [4];
		logic [23:0] t;
		int          i;
		if (k == 0) begin
			set_reg(cdp_pkg::CFG_PAT_FIRST, '1);
			set_reg(cdp_pkg::CFG_PAT_SECOND, '1);
			set_reg(cdp_pkg::CFG_LEN_ONE, 64'd4095);
			set_reg(cdp_pkg::CFG_LEN_TWO, 64'd4095);
			set_reg(cdp_pkg::CFG_LEN_THREE, 64'd4095);
			set_reg(cdp_pkg::CFG_LEN_FOUR, 64'd4095);
			set_reg(cdp_pkg::CFG_TAIL, 64'hFFFFFF);
		end else if (k == 1) begin
			set_reg(cdp_pkg::CFG_PAT_FIRST, '0);
			set_reg(cdp_pkg::CFG_PAT_SECOND, '0);
			set_reg(cdp_pkg::CFG_LEN_ONE, '0);
			set_reg(cdp_pkg::CFG_LEN_TWO, '0);
			set_reg(cdp_pkg::CFG_LEN_THREE, '0);
			set_reg(cdp_pkg::CFG_LEN_FOUR, '0);
			set_reg(cdp_pkg::CFG_TAIL, '0);
		end else begin
			for (i = 0; i < 4; i++)
				l[i] = $urandom_range(0, 1) ? 12'd0 : pick_len();
			t = 24'(shaped_word());
			if ($urandom_range(0, 2) == 0)
				t[23:22] = 2'b00;
			set_reg(cdp_pkg::CFG_PAT_FIRST, {shaped_word(), shaped_word()});
			set_reg(cdp_pkg::CFG_PAT_SECOND, {shaped_word(), shaped_word()});
			set_reg(cdp_pkg::CFG_LEN_ONE, 64'(l[0]));
			set_reg(cdp_pkg::CFG_LEN_TWO, 64'(l[1]));
			set_reg(cdp_pkg::CFG_LEN_THREE, 64'(l[2]));
			set_reg(cdp_pkg::CFG_LEN_FOUR, 64'(l[3]));
			set_reg(cdp_pkg::CFG_TAIL, 64'(t));
		end
	endtask

	always @(posedge clk) begin : out_check
		exp_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (due_words.size() == 0) begin
				$display("%0t: unexpected word, expected none, got soft_out %0d frame_end %0b",
					$time, $signed(m_tdata), m_tlast);
				mismatches++;
			end else begin
				want = due_words.pop_front();
				if (m_tdata !== want.val || m_tlast !== want.last) begin
					$display("%0t: expected soft_out %0d frame_end %0b, got %0d %0b",
						$time, $signed(want.val), want.last, $signed(m_tdata), m_tlast);
					mismatches++;
				end
			end
		end
		m_tready <= ($urandom_range(0, 99) >= rx_pct);
	end

	initial begin
		#4000000;
		$display("FAIL convolutional_depuncturer_top");
		$finish;
	end

	initial begin
		int   r;
		int   p;
		int   q;
		int   j;
		exp_t want;
		pat_first = '1;
		pat_second = '1;
		seg_len[0] = 12'd1;
		seg_len[1] = 12'd0;
		seg_len[2] = 12'd0;
		seg_len[3] = 12'd0;
		tail_word = 24'hFFFFFF;
		seg_at = '0;
		rep_at = '0;
		pos_at = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (r = 0; r < PLAN_LEN; r++) begin
			if (plan[r].is_cfg) begin
				s_tvalid <= 1'b0;
				drain();
				set_reg(plan[r].addr, plan[r].value);
			end else begin
				want.val = plan[r].want_soft;
				want.last = plan[r].want_last;
				send_word(plan[r].din, plan[r].typed, want);
			end
		end

		want = '0;
		for (p = 0; p < 3; p++) begin
			tx_pct = (p == 0) ? 31 : (p == 1) ? 78 : 0;
			rx_pct = (p == 0) ? 78 : (p == 1) ? 31 : 0;
			for (q = 0; q < 3; q++) begin
				s_tvalid <= 1'b0;
				drain();
				load_setting(p * 3 + q);
				for (j = 0; j < RANDOM_PER_SETTING; j++)
					send_word(pick_soft(), 1'b0, want);
			end
		end
		s_tvalid <= 1'b0;
		drain();

		if (mismatches == 0)
			$display("PASS convolutional_depuncturer_top");
		else
			$display("FAIL convolutional_depuncturer_top");
		$finish;
	end

endmodule
